// ===== hdl/assert_macros.svh =====
// Assertion helpers included by the RTL file elastic_ball_collision_step.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every rising clock edge outside reset.
`define ASSERT_HOLDS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a condition in one cycle is followed by another in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/ebc_pkg.sv =====
package ebc_pkg;

    typedef logic signed [18:0] pos_t;
    typedef logic signed [16:0] vel_t;

    typedef struct packed {
        pos_t        pos_x;
        pos_t        pos_y;
        pos_t        org_x;
        pos_t        org_y;
        vel_t        vel_x;
        vel_t        vel_y;
        logic [31:0] org_t;
        logic [5:0]  radius;
        logic [11:0] mass;
    } ball_rec_t;

    localparam int REC_W = $bits(ball_rec_t);

    typedef enum logic [1:0] {
        CMD_LOAD    = 2'd0,
        CMD_ADVANCE = 2'd1,
        CMD_READ    = 2'd2
    } cmd_t;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam logic [CFG_IDX_W-1:0] CFG_WORLD_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WORLD_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BALL_COUNT   = 2'd2;

    localparam logic [9:0]  WORLD_WIDTH_RST  = 10'd800;
    localparam logic [9:0]  WORLD_HEIGHT_RST = 10'd600;
    localparam logic [10:0] BALL_COUNT_RST   = 11'd1000;

    // Wide index used for range checks against MAX_BALLS (up to 4096).
    localparam int IDX_WIDE_W = 13;

    // Restoring divider: one quotient bit per step over a 63-bit magnitude.
    localparam int DIV_STEPS = 63;
    localparam int DIV_CNT_W = 6;

    localparam vel_t VEL_MAX_V = 17'sh0FFFF;
    localparam vel_t VEL_MIN_V = 17'sh10000;
    localparam pos_t POS_MAX_V = 19'sh3FFFF;
    localparam pos_t POS_MIN_V = 19'sh40000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_J_LOAD,
        ST_I_LOAD,
        ST_PAIR_MUL,
        ST_PAIR_TEST,
        ST_MUL1,
        ST_MUL2,
        ST_DIV_LOAD,
        ST_DIV_STEP,
        ST_DIV_DONE,
        ST_APPLY,
        ST_WB_I,
        ST_NEXT_I,
        ST_POS_MUL,
        ST_POS_FIN
    } state_t;

    function automatic vel_t sat_vel(input logic signed [21:0] v);
        if (v > 22'sd65535) begin
            return VEL_MAX_V;
        end
        else if (v < -22'sd65536) begin
            return VEL_MIN_V;
        end
        else begin
            return v[16:0];
        end
    endfunction

    function automatic vel_t neg_sat(input vel_t v);
        if (v == VEL_MIN_V) begin
            return VEL_MAX_V;
        end
        else begin
            return -v;
        end
    endfunction

    // origin + prod/1024 truncated toward zero, saturated to position range
    function automatic pos_t pos_step(input pos_t org, input logic signed [49:0] prod);
        logic signed [49:0] adj;
        logic signed [49:0] q;
        logic signed [50:0] s;
        adj = prod + (prod[49] ? 50'sd1023 : 50'sd0);
        q   = adj >>> 10;
        s   = {{32{org[18]}}, org} + {q[49], q};
        if (s > 51'sd262143) begin
            return POS_MAX_V;
        end
        else if (s < -51'sd262144) begin
            return POS_MIN_V;
        end
        else begin
            return s[18:0];
        end
    endfunction

endpackage

// ===== hdl/ebc_req_if.sv =====
interface ebc_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         command;
    logic [9:0]         ball_index;
    logic [5:0]         radius_px;
    logic [11:0]        mass_units;
    logic signed [18:0] load_pos_x;
    logic signed [18:0] load_pos_y;
    logic signed [16:0] load_vel_x;
    logic signed [16:0] load_vel_y;
    logic [31:0]        time_now;

    modport source (
        output valid, command, ball_index, radius_px, mass_units,
               load_pos_x, load_pos_y, load_vel_x, load_vel_y, time_now,
        input  ready
    );
    modport sink (
        input  valid, command, ball_index, radius_px, mass_units,
               load_pos_x, load_pos_y, load_vel_x, load_vel_y, time_now,
        output ready
    );
endinterface

// ===== hdl/ebc_res_if.sv =====
interface ebc_res_if;
    logic               valid;
    logic               ready;
    logic [9:0]         out_index;
    logic signed [18:0] out_pos_x;
    logic signed [18:0] out_pos_y;
    logic signed [16:0] out_vel_x;
    logic signed [16:0] out_vel_y;
    logic [5:0]         out_radius;

    modport source (
        output valid, out_index, out_pos_x, out_pos_y, out_vel_x, out_vel_y, out_radius,
        input  ready
    );
    modport sink (
        input  valid, out_index, out_pos_x, out_pos_y, out_vel_x, out_vel_y, out_radius,
        output ready
    );
endinterface

// ===== hdl/ebc_ram.sv =====
module ebc_ram #(
    parameter int WIDTH = 160,
    parameter int DEPTH = 1024
)(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/elastic_ball_collision_step.sv =====
// Read request: the RAM read data is registered, then the result register is loaded.
// Load request: the record is written as the request is accepted. Advance request: each
// ball j walks all balls i < j, and each colliding pair runs four 63-step divisions.
// One request at a time; all ball state sits in a single-port-read ball RAM.
// Reset (async, active low) restores the registers to 800/600/1000 and idles the
// sequencer; the ball RAM is not cleared and holds garbage until loaded.
`include "assert_macros.svh"

module elastic_ball_collision_step
    import ebc_pkg::*;
#(
    parameter int MAX_BALLS = 1024
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    ebc_req_if.sink               req,
    ebc_res_if.source             res
);

    localparam int AW = (MAX_BALLS > 1) ? $clog2(MAX_BALLS) : 1;
    localparam int CW = AW + 1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [9:0]  world_width_reg;
    logic [9:0]  world_height_reg;
    logic [10:0] ball_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            world_width_reg  <= WORLD_WIDTH_RST;
            world_height_reg <= WORLD_HEIGHT_RST;
            ball_count_reg   <= BALL_COUNT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_WORLD_WIDTH:  world_width_reg  <= cfg_data[9:0];
                CFG_WORLD_HEIGHT: world_height_reg <= cfg_data[9:0];
                CFG_BALL_COUNT:   ball_count_reg   <= cfg_data;
                default:          ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Ball RAM: one record per ball, read data valid in the cycle after the address
    // ------------------------------------------------------------------
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    ball_rec_t        ram_wdata;
    logic [AW-1:0]    ram_raddr;
    logic [REC_W-1:0] ram_rdata;
    ball_rec_t        rd_rec;

    ebc_ram #(
        .WIDTH (REC_W),
        .DEPTH (MAX_BALLS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_rec = ram_rdata;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t state_reg, state_next;

    logic [AW-1:0]        j_reg;
    logic [AW-1:0]        i_reg;
    logic [CW-1:0]        n_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [1:0]           div_sel_reg;
    logic                 out_valid_reg;

    logic [31:0]        t_reg;
    logic [9:0]         rd_idx_reg;
    logic               rd_ok_reg;
    ball_rec_t          jr_reg;     // cached ball j for the whole inner walk
    ball_rec_t          ir_reg;     // ball i under test
    logic signed [20:0] ax_reg, ay_reg;
    logic signed [17:0] dvx_reg, dvy_reg;
    logic [6:0]         rsum_reg;
    logic [12:0]        msum_reg;
    logic signed [41:0] sqx_reg, sqy_reg;
    logic signed [38:0] dpx_reg, dpy_reg;
    logic [13:0]        rs_sq_reg;
    logic signed [35:0] k_reg;
    logic [42:0]        den_reg;
    logic signed [52:0] px_reg, py_reg;
    logic signed [63:0] num_reg [4];
    logic [62:0]        div_mag_reg;
    logic [42:0]        div_rem_reg;
    logic [20:0]        div_q_reg;
    logic               div_neg_reg;
    logic signed [20:0] quo_reg [4];
    logic signed [49:0] prx_reg, pry_reg;

    logic [9:0]         out_index_reg;
    pos_t               out_pos_x_reg, out_pos_y_reg;
    vel_t               out_vel_x_reg, out_vel_y_reg;
    logic [5:0]         out_radius_reg;

    // ------------------------------------------------------------------
    // Request decode
    // ------------------------------------------------------------------
    cmd_t                  cmd;
    logic                  req_fire;
    logic [IDX_WIDE_W-1:0] idx_wide;
    logic                  idx_in_range;
    logic [AW-1:0]         idx_addr;
    logic [IDX_WIDE_W-1:0] bc_wide;
    logic [IDX_WIDE_W-1:0] n_wide;
    ball_rec_t             load_rec;

    assign cmd          = cmd_t'(req.command);
    assign req_fire     = req.valid && req.ready;
    assign idx_wide     = {3'd0, req.ball_index};
    assign idx_in_range = idx_wide < IDX_WIDE_W'(MAX_BALLS);
    assign idx_addr     = idx_wide[AW-1:0];
    assign bc_wide      = {2'd0, ball_count_reg};
    // clamp the walk at the RAM depth
    assign n_wide       = (bc_wide > IDX_WIDE_W'(MAX_BALLS)) ? IDX_WIDE_W'(MAX_BALLS) : bc_wide;

    always_comb
    begin
        load_rec.pos_x  = req.load_pos_x;
        load_rec.pos_y  = req.load_pos_y;
        load_rec.org_x  = req.load_pos_x;
        load_rec.org_y  = req.load_pos_y;
        load_rec.vel_x  = req.load_vel_x;
        load_rec.vel_y  = req.load_vel_y;
        load_rec.org_t  = req.time_now;
        load_rec.radius = req.radius_px;
        load_rec.mass   = req.mass_units;
    end

    // ------------------------------------------------------------------
    // Wall reflection on ball j as it comes out of the RAM
    // ------------------------------------------------------------------
    logic signed [19:0] lim_x, lim_y;
    logic               hit_x, hit_y;
    ball_rec_t          wall_rec;

    always_comb
    begin
        // right/bottom limit: (wall - 2r) * 256
        lim_x = $signed({2'd0, world_width_reg, 8'd0}) - $signed({5'd0, rd_rec.radius, 9'd0});
        lim_y = $signed({2'd0, world_height_reg, 8'd0}) - $signed({5'd0, rd_rec.radius, 9'd0});
        hit_x = ((rd_rec.pos_x <= 0) && (rd_rec.vel_x < 0)) ||
                (($signed({rd_rec.pos_x[18], rd_rec.pos_x}) >= lim_x) && (rd_rec.vel_x > 0));
        hit_y = ((rd_rec.pos_y <= 0) && (rd_rec.vel_y < 0)) ||
                (($signed({rd_rec.pos_y[18], rd_rec.pos_y}) >= lim_y) && (rd_rec.vel_y > 0));
        wall_rec = rd_rec;
        if (hit_x)
        begin
            wall_rec.vel_x = neg_sat(rd_rec.vel_x);
        end
        if (hit_y)
        begin
            wall_rec.vel_y = neg_sat(rd_rec.vel_y);
        end
        // any reversal restarts the movement from the current position
        if (hit_x || hit_y)
        begin
            wall_rec.org_x = rd_rec.pos_x;
            wall_rec.org_y = rd_rec.pos_y;
            wall_rec.org_t = t_reg;
        end
    end

    // ------------------------------------------------------------------
    // Pair datapath
    // ------------------------------------------------------------------
    logic signed [20:0] ax_next, ay_next;
    logic signed [17:0] dvx_next, dvy_next;
    logic signed [42:0] d2;
    logic signed [39:0] dot;
    logic               pair_hit;
    logic signed [40:0] k_full;
    logic [42:0]        den_next;
    logic               den_zero;

    always_comb
    begin
        // center difference j - i; corner plus r*256 on each side
        ax_next = {{2{jr_reg.pos_x[18]}}, jr_reg.pos_x} + {7'd0, jr_reg.radius, 8'd0}
                - {{2{rd_rec.pos_x[18]}}, rd_rec.pos_x} - {7'd0, rd_rec.radius, 8'd0};
        ay_next = {{2{jr_reg.pos_y[18]}}, jr_reg.pos_y} + {7'd0, jr_reg.radius, 8'd0}
                - {{2{rd_rec.pos_y[18]}}, rd_rec.pos_y} - {7'd0, rd_rec.radius, 8'd0};
        dvx_next = {jr_reg.vel_x[16], jr_reg.vel_x} - {rd_rec.vel_x[16], rd_rec.vel_x};
        dvy_next = {jr_reg.vel_y[16], jr_reg.vel_y} - {rd_rec.vel_y[16], rd_rec.vel_y};

        d2  = {sqx_reg[41], sqx_reg} + {sqy_reg[41], sqy_reg};
        dot = {dpx_reg[38], dpx_reg} + {dpy_reg[38], dpy_reg};
        // overlapping and approaching
        pair_hit = (d2 < $signed({13'd0, rs_sq_reg, 16'd0})) && (dot < 0);
        k_full   = -$signed({dot, 1'b0});
        // overlap bounds d2 below 2^30
        den_next = msum_reg * d2[29:0];
        den_zero = (den_reg == 43'd0);
    end

    // ------------------------------------------------------------------
    // Shared restoring divider, one quotient bit per cycle
    // ------------------------------------------------------------------
    logic signed [63:0] num_sel;
    logic signed [63:0] num_abs;
    logic [43:0]        rem_sh;
    logic               rem_ge;
    logic [43:0]        rem_sub;
    logic               div_last;
    logic signed [20:0] q_signed;

    always_comb
    begin
        num_sel  = num_reg[div_sel_reg];
        num_abs  = num_sel[63] ? -num_sel : num_sel;
        rem_sh   = {div_rem_reg, div_mag_reg[62]};
        rem_ge   = rem_sh >= {1'b0, den_reg};
        rem_sub  = rem_sh - {1'b0, den_reg};
        div_last = (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));
        // quotient magnitude stays below 2^19 for any overlapping pair
        q_signed = div_neg_reg ? -$signed(div_q_reg) : $signed(div_q_reg);
    end

    // ------------------------------------------------------------------
    // Loop control
    // ------------------------------------------------------------------
    logic [AW-1:0] i_inc;
    logic          i_last;
    logic [CW-1:0] j_inc;
    logic          j_last;
    logic [31:0]   dt;

    assign i_inc  = i_reg + AW'(1);
    assign i_last = (i_inc == j_reg);
    assign j_inc  = {1'b0, j_reg} + CW'(1);
    assign j_last = (j_inc == n_reg);
    assign dt     = t_reg - jr_reg.org_t;

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    case (cmd)
                        CMD_READ:    state_next = ST_READ;
                        CMD_ADVANCE: state_next = (n_wide == '0) ? ST_IDLE : ST_J_LOAD;
                        default:     state_next = ST_IDLE;
                    endcase
                end
            end
            ST_READ:      state_next = ST_IDLE;
            ST_J_LOAD:    state_next = (j_reg == '0) ? ST_POS_MUL : ST_I_LOAD;
            ST_I_LOAD:    state_next = ST_PAIR_MUL;
            ST_PAIR_MUL:  state_next = ST_PAIR_TEST;
            ST_PAIR_TEST: state_next = pair_hit ? ST_MUL1 : ST_NEXT_I;
            ST_MUL1:      state_next = den_zero ? ST_WB_I : ST_MUL2;
            ST_MUL2:      state_next = ST_DIV_LOAD;
            ST_DIV_LOAD:  state_next = ST_DIV_STEP;
            ST_DIV_STEP:  state_next = div_last ? ST_DIV_DONE : ST_DIV_STEP;
            ST_DIV_DONE:  state_next = (div_sel_reg == 2'd3) ? ST_APPLY : ST_DIV_LOAD;
            ST_APPLY:     state_next = ST_WB_I;
            ST_WB_I:      state_next = ST_NEXT_I;
            ST_NEXT_I:    state_next = i_last ? ST_POS_MUL : ST_I_LOAD;
            ST_POS_MUL:   state_next = ST_POS_FIN;
            ST_POS_FIN:   state_next = j_last ? ST_IDLE : ST_J_LOAD;
            default:      state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Outputs: handshake and RAM port controls
    // ------------------------------------------------------------------
    always_comb
    begin
        req.ready = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = jr_reg;
        ram_raddr = '0;
        case (state_reg)
            ST_IDLE:
            begin
                // hold a read request while the result register cannot drain
                req.ready = !out_valid_reg || res.ready || (cmd != CMD_READ);
                ram_we    = req.valid && req.ready && (cmd == CMD_LOAD) && idx_in_range;
                ram_waddr = idx_addr;
                ram_wdata = load_rec;
                ram_raddr = (cmd == CMD_READ) ? idx_addr : '0;
            end
            ST_NEXT_I:
            begin
                ram_raddr = i_inc;
            end
            ST_WB_I:
            begin
                ram_we    = 1'b1;
                ram_waddr = i_reg;
                ram_wdata = ir_reg;
            end
            ST_POS_FIN:
            begin
                ram_we          = 1'b1;
                ram_waddr       = j_reg;
                ram_wdata       = jr_reg;
                ram_wdata.pos_x = pos_step(jr_reg.org_x, prx_reg);
                ram_wdata.pos_y = pos_step(jr_reg.org_y, pry_reg);
                ram_raddr       = j_inc[AW-1:0];
            end
            default:
            begin
                ram_raddr = '0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            j_reg         <= '0;
            i_reg         <= '0;
            n_reg         <= '0;
            div_cnt_reg   <= '0;
            div_sel_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_READ)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (req_fire && (cmd == CMD_ADVANCE))
                    begin
                        j_reg <= '0;
                        n_reg <= n_wide[CW-1:0];
                    end
                end
                ST_J_LOAD:   i_reg       <= '0;
                ST_NEXT_I:   i_reg       <= i_inc;
                ST_MUL2:     div_sel_reg <= '0;
                ST_DIV_LOAD: div_cnt_reg <= '0;
                ST_DIV_STEP: div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
                ST_DIV_DONE: div_sel_reg <= div_sel_reg + 2'd1;
                ST_POS_FIN:  j_reg       <= j_inc[AW-1:0];
                default:     ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    t_reg      <= req.time_now;
                    rd_idx_reg <= req.ball_index;
                    rd_ok_reg  <= idx_in_range;
                end
            end
            ST_READ:
            begin
                out_index_reg  <= rd_idx_reg;
                out_pos_x_reg  <= rd_ok_reg ? rd_rec.pos_x  : '0;
                out_pos_y_reg  <= rd_ok_reg ? rd_rec.pos_y  : '0;
                out_vel_x_reg  <= rd_ok_reg ? rd_rec.vel_x  : '0;
                out_vel_y_reg  <= rd_ok_reg ? rd_rec.vel_y  : '0;
                out_radius_reg <= rd_ok_reg ? rd_rec.radius : '0;
            end
            ST_J_LOAD:
            begin
                jr_reg <= wall_rec;
            end
            ST_I_LOAD:
            begin
                ir_reg   <= rd_rec;
                ax_reg   <= ax_next;
                ay_reg   <= ay_next;
                dvx_reg  <= dvx_next;
                dvy_reg  <= dvy_next;
                rsum_reg <= {1'b0, jr_reg.radius} + {1'b0, rd_rec.radius};
                msum_reg <= {1'b0, jr_reg.mass} + {1'b0, rd_rec.mass};
            end
            ST_PAIR_MUL:
            begin
                sqx_reg   <= ax_reg * ax_reg;
                sqy_reg   <= ay_reg * ay_reg;
                dpx_reg   <= dvx_reg * ax_reg;
                dpy_reg   <= dvy_reg * ay_reg;
                rs_sq_reg <= rsum_reg * rsum_reg;
            end
            ST_PAIR_TEST:
            begin
                if (pair_hit)
                begin
                    // restart both balls from where they stand
                    jr_reg.org_x <= jr_reg.pos_x;
                    jr_reg.org_y <= jr_reg.pos_y;
                    jr_reg.org_t <= t_reg;
                    ir_reg.org_x <= ir_reg.pos_x;
                    ir_reg.org_y <= ir_reg.pos_y;
                    ir_reg.org_t <= t_reg;
                end
                k_reg   <= k_full[35:0];
                den_reg <= den_next;
            end
            ST_MUL1:
            begin
                // overlap bounds |a| below 2^15
                px_reg <= $signed(ax_reg[16:0]) * k_reg;
                py_reg <= $signed(ay_reg[16:0]) * k_reg;
            end
            ST_MUL2:
            begin
                num_reg[0] <= px_reg * $signed({1'b0, ir_reg.mass});
                num_reg[1] <= py_reg * $signed({1'b0, ir_reg.mass});
                num_reg[2] <= px_reg * $signed({1'b0, jr_reg.mass});
                num_reg[3] <= py_reg * $signed({1'b0, jr_reg.mass});
            end
            ST_DIV_LOAD:
            begin
                div_mag_reg <= num_abs[62:0];
                div_rem_reg <= '0;
                div_q_reg   <= '0;
                div_neg_reg <= num_sel[63];
            end
            ST_DIV_STEP:
            begin
                div_mag_reg <= {div_mag_reg[61:0], 1'b0};
                div_rem_reg <= rem_ge ? rem_sub[42:0] : rem_sh[42:0];
                div_q_reg   <= {div_q_reg[19:0], rem_ge};
            end
            ST_DIV_DONE:
            begin
                quo_reg[div_sel_reg] <= q_signed;
            end
            ST_APPLY:
            begin
                jr_reg.vel_x <= sat_vel({{5{jr_reg.vel_x[16]}}, jr_reg.vel_x}
                                        + {quo_reg[0][20], quo_reg[0]});
                jr_reg.vel_y <= sat_vel({{5{jr_reg.vel_y[16]}}, jr_reg.vel_y}
                                        + {quo_reg[1][20], quo_reg[1]});
                ir_reg.vel_x <= sat_vel({{5{ir_reg.vel_x[16]}}, ir_reg.vel_x}
                                        - {quo_reg[2][20], quo_reg[2]});
                ir_reg.vel_y <= sat_vel({{5{ir_reg.vel_y[16]}}, ir_reg.vel_y}
                                        - {quo_reg[3][20], quo_reg[3]});
            end
            ST_POS_MUL:
            begin
                prx_reg <= jr_reg.vel_x * $signed({1'b0, dt});
                pry_reg <= jr_reg.vel_y * $signed({1'b0, dt});
            end
            default: ;
        endcase
    end

    assign res.valid      = out_valid_reg;
    assign res.out_index  = out_index_reg;
    assign res.out_pos_x  = out_pos_x_reg;
    assign res.out_pos_y  = out_pos_y_reg;
    assign res.out_vel_x  = out_vel_x_reg;
    assign res.out_vel_y  = out_vel_y_reg;
    assign res.out_radius = out_radius_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ASSERT_HOLDS(a_ready_idle, !req.ready || (state_reg == ST_IDLE), "ready outside idle")
    `ASSERT_NEXT(a_read_result, state_reg == ST_READ, out_valid_reg, "read gave no result")
    `ASSERT_HOLDS(a_i_below_j, (state_reg != ST_I_LOAD) || (i_reg < j_reg), "i not below j")
    `ASSERT_HOLDS(a_wb_states, !(ram_we && (state_reg != ST_IDLE)) ||
        (state_reg == ST_WB_I) || (state_reg == ST_POS_FIN), "RAM write in wrong state")

endmodule

// ===== bench/ball_checker.sv =====
module ball_checker
    import ebc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    ebc_req_if                    req,
    ebc_res_if                    res,
    output int                    errors,
    output int                    pending,
    output int                    reads_checked
);

    localparam int NBALLS = 1024;

    typedef struct {
        logic [9:0] idx;
        pos_t       px;
        pos_t       py;
        vel_t       vx;
        vel_t       vy;
        logic [5:0] r;
    } ball_view_t;

    logic [9:0]  world_w;
    logic [9:0]  world_h;
    logic [10:0] walk_count;

    pos_t        cur_x   [NBALLS];
    pos_t        cur_y   [NBALLS];
    pos_t        start_x [NBALLS];
    pos_t        start_y [NBALLS];
    vel_t        speed_x [NBALLS];
    vel_t        speed_y [NBALLS];
    logic [31:0] start_t [NBALLS];
    logic [5:0]  rad     [NBALLS];
    logic [11:0] mass    [NBALLS];

    ball_view_t  read_queue[$];

    function automatic vel_t clamp_vel(longint v);
        if (v > 65535) return vel_t'(65535);
        if (v < -65536) return vel_t'(-65536);
        return vel_t'(v);
    endfunction

    function automatic pos_t clamp_pos(longint v);
        if (v > 262143) return pos_t'(262143);
        if (v < -262144) return pos_t'(-262144);
        return pos_t'(v);
    endfunction

    function void restart_motion(int b, logic [31:0] t);
        start_x[b] = cur_x[b];
        start_y[b] = cur_y[b];
        start_t[b] = t;
    endfunction

    // Walk the balls in index order: walls, pair collisions, then new position.
    function void advance_world(logic [31:0] t);
        int n;
        longint rj, ri, px, py, vx, vy, ax, ay, rs, d2, dot, mi, mj, den, k, dtl;
        logic [31:0] dt;
        n = (walk_count > NBALLS) ? NBALLS : int'(walk_count);
        for (int j = 0; j < n; j++) begin
            rj = rad[j];
            px = cur_x[j];
            py = cur_y[j];
            vx = speed_x[j];
            vy = speed_y[j];
            if ((px <= 0 && vx < 0) || (px >= (longint'(world_w) - 2 * rj) * 256 && vx > 0))
            begin
                speed_x[j] = clamp_vel(-vx);
                restart_motion(j, t);
            end
            if ((py <= 0 && vy < 0) || (py >= (longint'(world_h) - 2 * rj) * 256 && vy > 0))
            begin
                speed_y[j] = clamp_vel(-vy);
                restart_motion(j, t);
            end
            for (int i = 0; i < j; i++) begin
                ri = rad[i];
                ax = (longint'(cur_x[j]) + rj * 256) - (longint'(cur_x[i]) + ri * 256);
                ay = (longint'(cur_y[j]) + rj * 256) - (longint'(cur_y[i]) + ri * 256);
                rs = (ri + rj) * 256;
                d2 = ax * ax + ay * ay;
                if (d2 >= rs * rs) continue;
                dot = (longint'(speed_x[j]) - longint'(speed_x[i])) * ax
                    + (longint'(speed_y[j]) - longint'(speed_y[i])) * ay;
                if (dot >= 0) continue;
                restart_motion(j, t);
                restart_motion(i, t);
                mi = mass[i];
                mj = mass[j];
                den = (mi + mj) * d2;
                if (den <= 0) continue;
                k = -2 * dot;
                speed_x[j] = clamp_vel(longint'(speed_x[j]) + (ax * k * mi) / den);
                speed_y[j] = clamp_vel(longint'(speed_y[j]) + (ay * k * mi) / den);
                speed_x[i] = clamp_vel(longint'(speed_x[i]) - (ax * k * mj) / den);
                speed_y[i] = clamp_vel(longint'(speed_y[i]) - (ay * k * mj) / den);
            end
            dt  = t - start_t[j];
            dtl = longint'(dt);
            cur_x[j] = clamp_pos(longint'(start_x[j]) + (longint'(speed_x[j]) * dtl) / 1024);
            cur_y[j] = clamp_pos(longint'(start_y[j]) + (longint'(speed_y[j]) * dtl) / 1024);
        end
    endfunction

    function void check_field(string name, longint want, longint got);
        if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
        end
    endfunction

    assign pending = read_queue.size();

    always @(posedge clk or negedge rst_n) begin
        ball_view_t want;
        ball_view_t got;
        if (!rst_n) begin
            world_w    <= WORLD_WIDTH_RST;
            world_h    <= WORLD_HEIGHT_RST;
            walk_count <= BALL_COUNT_RST;
            read_queue.delete();
        end
        else begin
            if (res.valid && res.ready) begin
                got = '{res.out_index, res.out_pos_x, res.out_pos_y,
                        res.out_vel_x, res.out_vel_y, res.out_radius};
                if (read_queue.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, expected none actual index %0d",
                             $time, got.idx);
                end
                else begin
                    want = read_queue.pop_front();
                    reads_checked++;
                    check_field("index", want.idx, got.idx);
                    check_field("pos_x", want.px, got.px);
                    check_field("pos_y", want.py, got.py);
                    check_field("vel_x", want.vx, got.vx);
                    check_field("vel_y", want.vy, got.vy);
                    check_field("radius", want.r, got.r);
                end
            end
            if (req.valid && req.ready) begin
                case (req.command)
                    CMD_LOAD:
                    begin
                        rad[req.ball_index]     = req.radius_px;
                        mass[req.ball_index]    = req.mass_units;
                        cur_x[req.ball_index]   = req.load_pos_x;
                        cur_y[req.ball_index]   = req.load_pos_y;
                        speed_x[req.ball_index] = req.load_vel_x;
                        speed_y[req.ball_index] = req.load_vel_y;
                        restart_motion(req.ball_index, req.time_now);
                    end
                    CMD_ADVANCE: advance_world(req.time_now);
                    CMD_READ:
                    begin
                        want = '{req.ball_index, cur_x[req.ball_index], cur_y[req.ball_index],
                                 speed_x[req.ball_index], speed_y[req.ball_index],
                                 rad[req.ball_index]};
                        read_queue.push_back(want);
                    end
                    default: ;
                endcase
            end
            if (cfg_we) begin
                case (cfg_index)
                    CFG_WORLD_WIDTH:  world_w    <= cfg_data[9:0];
                    CFG_WORLD_HEIGHT: world_h    <= cfg_data[9:0];
                    CFG_BALL_COUNT:   walk_count <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    initial
    begin
        errors = 0;
        reads_checked = 0;
    end

endmodule

// ===== bench/testbench.sv =====
module testbench;
    import ebc_pkg::*;

    // command code the block must ignore
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    ebc_req_if req ();
    ebc_res_if res ();

    int errors;
    int pending;
    int reads_checked;

    // stimulus bookkeeping
    bit          loaded[1024];
    bit          no_gaps;
    logic [31:0] sim_clock;
    int          n_loads;
    int          n_steps;
    int          n_total;

    elastic_ball_collision_step i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req.sink),
        .res       (res.source)
    );

    ball_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .req           (req),
        .res           (res),
        .errors        (errors),
        .pending       (pending),
        .reads_checked (reads_checked)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Hand one request to the block: drop valid for a random gap, then hold
    // the request until it is taken.
    task automatic send_request(logic [1:0] cmd, logic [9:0] idx, logic [5:0] r,
                                logic [11:0] m, pos_t px, pos_t py, vel_t vx, vel_t vy,
                                logic [31:0] t);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 11);
        @(negedge clk);
        if (gap > 0)
        begin
            req.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req.command    = cmd;
        req.ball_index = idx;
        req.radius_px  = r;
        req.mass_units = m;
        req.load_pos_x = px;
        req.load_pos_y = py;
        req.load_vel_x = vx;
        req.load_vel_y = vy;
        req.time_now   = t;
        req.valid      = 1'b1;
        n_total++;
        @(posedge clk);
        while (!req.ready) @(posedge clk);
    endtask

    task automatic load_ball(logic [9:0] idx, logic [5:0] r, logic [11:0] m,
                             pos_t px, pos_t py, vel_t vx, vel_t vy);
        send_request(CMD_LOAD, idx, r, m, px, py, vx, vy, sim_clock);
        loaded[idx] = 1'b1;
        n_loads++;
    endtask

    task automatic step_to(logic [31:0] t);
        sim_clock = t;
        send_request(CMD_ADVANCE, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, t);
        n_steps++;
    endtask

    task automatic read_ball(logic [9:0] idx);
        send_request(CMD_READ, idx, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom);
    endtask

    // Drain the block: a read cannot start before an advance finishes, so
    // once its result is back the block is idle.
    task automatic drain();
        if (loaded[0]) read_ball(10'd0);
        @(negedge clk);
        req.valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    // Random ball: mostly packed into a small corner so collisions happen,
    // sometimes any position and speed at all.
    task automatic random_ball(logic [9:0] idx);
        if ($urandom_range(0, 4) == 0)
            load_ball(idx, $urandom_range(1, 63), $urandom_range(1, 4095), $urandom,
                      $urandom, $urandom, $urandom);
        else
            load_ball(idx, $urandom_range(1, 20), $urandom_range(1, 4095),
                      $urandom_range(0, 120 * 256), $urandom_range(0, 120 * 256),
                      vel_t'($signed($urandom_range(0, 8000)) - 4000),
                      vel_t'($signed($urandom_range(0, 8000)) - 4000));
    endtask

    // Drive the result side: stall for a random count before each result,
    // and about one result in four with no stall.
    initial
    begin
        int stall;
        res.ready = 1'b0;
        forever
        begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
            repeat (stall)
            begin
                @(negedge clk);
                res.ready = 1'b0;
            end
            @(negedge clk);
            res.ready = 1'b1;
            @(posedge clk);
            while (!res.valid) @(posedge clk);
        end
    end

    initial
    begin
        int n;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_WORLD_WIDTH;
        cfg_data       = '0;
        req.valid      = 1'b0;
        req.command    = CMD_LOAD;
        req.ball_index = '0;
        req.radius_px  = '0;
        req.mass_units = '0;
        req.load_pos_x = '0;
        req.load_pos_y = '0;
        req.load_vel_x = '0;
        req.load_vel_y = '0;
        req.time_now   = '0;
        sim_clock      = '0;
        no_gaps        = 1'b0;
        n_loads        = 0;
        n_steps        = 0;
        n_total        = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: head-on pair, then a ball stuck on the top-left walls
        // at the most negative speed, reversing to the saturated maximum.
        write_reg(CFG_WORLD_WIDTH, 11'd1023);
        write_reg(CFG_WORLD_HEIGHT, 11'd1023);
        write_reg(CFG_BALL_COUNT, 11'd3);
        load_ball(10'd0, 6'd10, 12'd4095, 100 * 256, 100 * 256, 17'sd1000, 17'sd0);
        load_ball(10'd1, 6'd10, 12'd1, 115 * 256, 100 * 256, -17'sd1000, 17'sd5);
        load_ball(10'd2, 6'd63, 12'd4095, -19'sd262144, -19'sd262144,
                  -17'sd65536, -17'sd65536);
        load_ball(10'd1023, 6'd63, 12'd4095, 19'sd262143, 19'sd262143,
                  17'sd65535, 17'sd65535);
        step_to(32'd1024);
        read_ball(10'd0);
        read_ball(10'd1);
        read_ball(10'd2);
        read_ball(10'd1023);
        send_request(CMD_UNUSED, 10'd5, 6'd1, 12'd1, '0, '0, '0, '0, '0);
        step_to(32'hFFFF_FFFF);
        read_ball(10'd2);
        drain();

        // Narrow world: every ball sits beyond the right and bottom walls.
        write_reg(CFG_WORLD_WIDTH, 11'd1);
        write_reg(CFG_WORLD_HEIGHT, 11'd1);
        write_reg(CFG_BALL_COUNT, 11'd1);
        load_ball(10'd0, 6'd1, 12'd7, 19'sd256, 19'sd256, 17'sd65535, 17'sd300);
        step_to(32'd5);
        read_ball(10'd0);
        drain();

        // Largest walk count: reads only, never walked.
        write_reg(CFG_BALL_COUNT, 11'd1024);
        read_ball(10'd1023);
        drain();

        // Random phases: fresh world, a few balls, then steps, loads, unused commands and reads.
        while (n_total < 125)
        begin
            no_gaps = ($urandom_range(0, 3) == 0);
            n = $urandom_range(1, 8);
            write_reg(CFG_WORLD_WIDTH, $urandom_range(1, 1023));
            write_reg(CFG_WORLD_HEIGHT, $urandom_range(1, 1023));
            write_reg(CFG_BALL_COUNT, n);
            for (int b = 0; b < n; b++) random_ball(b);
            repeat ($urandom_range(4, 10))
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2:
                        step_to(($urandom_range(0, 9) == 0) ? $urandom
                                : sim_clock + $urandom_range(0, 4096));
                    3:
                        random_ball($urandom_range(0, 1023));
                    4:
                        send_request(CMD_UNUSED, $urandom, $urandom, $urandom, $urandom,
                                     $urandom, $urandom, $urandom, $urandom);
                    default:
                    begin
                        if ($urandom_range(0, 3) == 0 && loaded[1023]) read_ball(10'd1023);
                        else read_ball($urandom_range(0, n - 1));
                    end
                endcase
            end
            drain();
        end

        repeat (50) @(negedge clk);
        $display("covered %0d requests: %0d loads, %0d time steps, %0d reads checked",
                 n_total, n_loads, n_steps, reads_checked);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Hold a hard ceiling on run time.
    initial
    begin
        #8000000;
        $display("status: fail");
        $finish;
    end

endmodule
